FILE: rtl/mvenv_pkg.sv
// shared types and constants of the multichannel volume envelope unit
// used by mvenv_cfg, multichannel_volume_envelope_unit and the dv checker and testbench, no dependencies
package mvenv_pkg;

    localparam int CHANNELS_DEF      = 6;
    localparam int SUSTAIN_STEPS_DEF = 15;

    localparam int RATE_W  = 8;
    localparam int LEVEL_W = 4;
    localparam int COUNT_W = 16;
    localparam int CHAN_W  = 3;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [7:0] PERIOD_SCALE_RST = 8'd3;
    localparam logic       STEREO_MODE_RST  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PERIOD_SCALE = 1'b0;
    localparam logic REG_STEREO_MODE  = 1'b1;

    typedef enum logic [1:0] {
        STG_IDLE    = 2'd0,
        STG_ATTACK  = 2'd1,
        STG_SUSTAIN = 2'd2,
        STG_DECAY   = 2'd3
    } stage_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_PICK,
        SQ_ADV,
        SQ_START,
        SQ_ENTER,
        SQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [RATE_W-1:0] period_scale;
        logic              stereo_mode;
    } cfg_t;

endpackage

FILE: rtl/multichannel_volume_envelope_unit.sv
// top level of the multichannel attack/sustain/decay volume envelope
// depends on mvenv_pkg and mvenv_cfg
//
//  channel   direction  tdata fields (low bit up)                          side bits
//  s_        in         channel, attack, sustain, decay, peak, repeat      tuser: func
//  m_        out        volume_reg, volume_data                            tlast: last
//  apb       in/out     period_scale at 0x0, stereo_mode at 0x4            pready high
//
// a note-on steps through start, enter with the period multiply, write.
// a tick steps, per active channel, through pick, advance, up to two
// phase entries and a restart through the one shared period multiplier, write.
// aresetn clears every channel to idle, level zero; no clearing pass.
// s_tready is high only while the sequencer is idle; a write waits in the
// sequencer while the output register is still held by m_tready low.
module multichannel_volume_envelope_unit #(
    parameter int CHANNELS      = mvenv_pkg::CHANNELS_DEF,
    parameter int SUSTAIN_STEPS = mvenv_pkg::SUSTAIN_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // channel[2:0], attack_rate[10:3], sustain_rate[18:11], decay_rate[26:19],
    // peak_volume[30:27], repeat_on[31]
    input  logic [31:0]                   s_tdata,
    // func[0]
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // volume_reg[2:0], volume_data[10:3], zero pad[15:11]
    output logic [15:0]                   m_tdata,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mvenv_pkg::PADDR_W-1:0] paddr,
    input  logic [mvenv_pkg::PDATA_W-1:0] pwdata,
    output logic [mvenv_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW   = mvenv_pkg::RATE_W;
    localparam int LW   = mvenv_pkg::LEVEL_W;
    localparam int CW   = mvenv_pkg::COUNT_W;

    mvenv_pkg::cfg_t cfg;

    mvenv_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input fields
    logic                         in_func;
    logic [mvenv_pkg::CHAN_W-1:0] in_chan;
    logic [RW-1:0]                in_att, in_sus, in_dec;
    logic [LW-1:0]                in_peak;
    logic                         in_rep;
    logic                         in_chan_ok;

    assign in_func    = s_tuser[0];
    assign in_chan    = s_tdata[2:0];
    assign in_att     = s_tdata[10:3];
    assign in_sus     = s_tdata[18:11];
    assign in_dec     = s_tdata[26:19];
    assign in_peak    = s_tdata[30:27];
    assign in_rep     = s_tdata[31];
    assign in_chan_ok = (32'(in_chan) < 32'(CHANNELS));

    // per-channel state
    logic [CHANNELS-1:0] active_reg;
    logic [CHANNELS-1:0] rep_reg;
    mvenv_pkg::stage_t   stage_reg [CHANNELS];
    logic [RW-1:0]       att_reg   [CHANNELS];
    logic [RW-1:0]       sus_reg   [CHANNELS];
    logic [RW-1:0]       dec_reg   [CHANNELS];
    logic [LW-1:0]       peak_reg  [CHANNELS];
    logic [LW-1:0]       level_reg [CHANNELS];
    logic [CW-1:0]       pc_reg    [CHANNELS];
    logic [LW-1:0]       sl_reg    [CHANNELS];

    // sequencer
    mvenv_pkg::seq_state_t state_reg, state_next;
    logic [CH_W-1:0]       cur_reg, cur_next;
    logic [CHANNELS-1:0]   pend_reg, pend_next;
    logic                  last_reg, last_next;
    logic                  tick_reg, tick_next;
    logic                  restart_reg, restart_next;
    mvenv_pkg::stage_t     from_reg, from_next;

    // write strobes into the channel state at cur_reg (load_we writes at cur_next)
    logic              load_we;
    logic              act_we, act_wd;
    logic              stg_we;
    mvenv_pkg::stage_t stg_wd;
    logic              lvl_we;
    logic [LW-1:0]     lvl_wd;
    logic              pc_we;
    logic [CW-1:0]     pc_wd;
    logic              sl_we;
    logic [LW-1:0]     sl_wd;

    // output register
    logic              out_we;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              m_tlast_reg;

    // current channel view
    mvenv_pkg::stage_t cur_stage;
    logic [RW-1:0]     cur_att, cur_sus, cur_dec;
    logic [LW-1:0]     cur_peak, cur_level, cur_sl;
    logic [CW-1:0]     cur_pc;
    logic              cur_rep;

    assign cur_stage = stage_reg[cur_reg];
    assign cur_att   = att_reg[cur_reg];
    assign cur_sus   = sus_reg[cur_reg];
    assign cur_dec   = dec_reg[cur_reg];
    assign cur_peak  = peak_reg[cur_reg];
    assign cur_level = level_reg[cur_reg];
    assign cur_sl    = sl_reg[cur_reg];
    assign cur_pc    = pc_reg[cur_reg];
    assign cur_rep   = rep_reg[cur_reg];

    function automatic logic [RW-1:0] rate_sel(input mvenv_pkg::stage_t st,
                                               input logic [RW-1:0] a,
                                               input logic [RW-1:0] s,
                                               input logic [RW-1:0] d);
        case (st)
            mvenv_pkg::STG_ATTACK:  rate_sel = a;
            mvenv_pkg::STG_SUSTAIN: rate_sel = s;
            mvenv_pkg::STG_DECAY:   rate_sel = d;
            default:                rate_sel = '0;
        endcase
    endfunction

    // shared period multiplier
    logic [RW-1:0] mul_rate;
    logic [CW-1:0] mul_out;

    assign mul_out = CW'(cfg.period_scale) * CW'(mul_rate);

    // first phase at or after from_reg with a nonzero rate
    logic              ent_found;
    mvenv_pkg::stage_t ent_stage;

    always_comb begin
        ent_found = 1'b1;
        if (from_reg == mvenv_pkg::STG_ATTACK && cur_att != '0) begin
            ent_stage = mvenv_pkg::STG_ATTACK;
        end else if (from_reg != mvenv_pkg::STG_DECAY && cur_sus != '0) begin
            ent_stage = mvenv_pkg::STG_SUSTAIN;
        end else if (cur_dec != '0) begin
            ent_stage = mvenv_pkg::STG_DECAY;
        end else begin
            ent_stage = mvenv_pkg::STG_IDLE;
            ent_found = 1'b0;
        end
    end

    // lowest pending channel
    logic [CH_W-1:0]     pick_idx;
    logic [CHANNELS-1:0] pend_left;

    always_comb begin
        pick_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pick_idx = CH_W'(i);
            end
        end
        pend_left = pend_reg & ~(CHANNELS'(1) << pick_idx);
    end

    logic          expired;
    logic [LW-1:0] lv_inc, lv_dec, sl_dec;
    logic          slot_free;

    assign expired   = (cur_pc <= CW'(1));
    assign lv_inc    = (cur_level < cur_peak) ? cur_level + LW'(1) : cur_level;
    assign lv_dec    = (cur_level != '0) ? cur_level - LW'(1) : cur_level;
    assign sl_dec    = (cur_sl != '0) ? cur_sl - LW'(1) : cur_sl;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mvenv_pkg::SQ_IDLE;
            cur_reg     <= '0;
            pend_reg    <= '0;
            last_reg    <= 1'b0;
            tick_reg    <= 1'b0;
            restart_reg <= 1'b0;
            from_reg    <= mvenv_pkg::STG_ATTACK;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            last_reg    <= last_next;
            tick_reg    <= tick_next;
            restart_reg <= restart_next;
            from_reg    <= from_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        last_next    = last_reg;
        tick_next    = tick_reg;
        restart_next = restart_reg;
        from_next    = from_reg;
        s_tready     = 1'b0;
        load_we      = 1'b0;
        act_we       = 1'b0;
        act_wd       = 1'b0;
        stg_we       = 1'b0;
        stg_wd       = mvenv_pkg::STG_IDLE;
        lvl_we       = 1'b0;
        lvl_wd       = '0;
        pc_we        = 1'b0;
        pc_wd        = '0;
        sl_we        = 1'b0;
        sl_wd        = '0;
        out_we       = 1'b0;
        mul_rate     = rate_sel(cur_stage, cur_att, cur_sus, cur_dec);

        case (state_reg)
            mvenv_pkg::SQ_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_func) begin
                        if (in_chan_ok) begin
                            load_we      = 1'b1;
                            cur_next     = CH_W'(in_chan);
                            tick_next    = 1'b0;
                            restart_next = 1'b1;
                            state_next   = mvenv_pkg::SQ_START;
                        end
                    end else if (active_reg != '0) begin
                        pend_next  = active_reg;
                        tick_next  = 1'b1;
                        state_next = mvenv_pkg::SQ_PICK;
                    end
                end
            end

            mvenv_pkg::SQ_PICK: begin
                cur_next     = pick_idx;
                pend_next    = pend_left;
                last_next    = (pend_left == '0);
                restart_next = 1'b0;
                state_next   = mvenv_pkg::SQ_ADV;
            end

            mvenv_pkg::SQ_ADV: begin
                pc_we      = 1'b1;
                pc_wd      = expired ? mul_out : cur_pc - CW'(1);
                state_next = mvenv_pkg::SQ_EMIT;
                if (expired) begin
                    case (cur_stage)
                        mvenv_pkg::STG_ATTACK: begin
                            lvl_we = 1'b1;
                            lvl_wd = lv_inc;
                            if (lv_inc >= cur_peak) begin
                                from_next  = mvenv_pkg::STG_SUSTAIN;
                                state_next = mvenv_pkg::SQ_ENTER;
                            end
                        end
                        mvenv_pkg::STG_SUSTAIN: begin
                            sl_we = 1'b1;
                            sl_wd = sl_dec;
                            if (sl_dec == '0) begin
                                // no decay phase: level falls straight to zero
                                if (cur_dec == '0) begin
                                    lvl_we = 1'b1;
                                    lvl_wd = '0;
                                end
                                from_next  = mvenv_pkg::STG_DECAY;
                                state_next = mvenv_pkg::SQ_ENTER;
                            end
                        end
                        mvenv_pkg::STG_DECAY: begin
                            lvl_we = 1'b1;
                            lvl_wd = lv_dec;
                            if (lv_dec == '0) begin
                                stg_we = 1'b1;
                                stg_wd = mvenv_pkg::STG_IDLE;
                                act_we = 1'b1;
                                act_wd = 1'b0;
                                if (cur_rep) begin
                                    state_next = mvenv_pkg::SQ_START;
                                end
                            end
                        end
                        default: begin
                            act_we = 1'b1;
                            act_wd = 1'b0;
                            if (cur_rep) begin
                                state_next = mvenv_pkg::SQ_START;
                            end
                        end
                    endcase
                end
            end

            mvenv_pkg::SQ_START: begin
                if (cur_sus != '0) begin
                    sl_we = 1'b1;
                    sl_wd = LW'(SUSTAIN_STEPS);
                end
                lvl_we       = 1'b1;
                lvl_wd       = (cur_att == '0) ? cur_peak : '0;
                from_next    = mvenv_pkg::STG_ATTACK;
                restart_next = 1'b1;
                state_next   = mvenv_pkg::SQ_ENTER;
            end

            mvenv_pkg::SQ_ENTER: begin
                mul_rate = rate_sel(ent_stage, cur_att, cur_sus, cur_dec);
                stg_we   = 1'b1;
                stg_wd   = ent_stage;
                act_we   = 1'b1;
                act_wd   = ent_found;
                if (ent_found) begin
                    pc_we      = 1'b1;
                    pc_wd      = mul_out;
                    state_next = mvenv_pkg::SQ_EMIT;
                end else if (!restart_reg && cur_rep) begin
                    state_next = mvenv_pkg::SQ_START;
                end else begin
                    state_next = mvenv_pkg::SQ_EMIT;
                end
            end

            mvenv_pkg::SQ_EMIT: begin
                if (slot_free) begin
                    out_we = 1'b1;
                    if (tick_reg && pend_reg != '0) begin
                        state_next = mvenv_pkg::SQ_PICK;
                    end else begin
                        state_next = mvenv_pkg::SQ_IDLE;
                    end
                end
            end

            default: begin
                state_next = mvenv_pkg::SQ_IDLE;
            end
        endcase
    end

    // channel state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            rep_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                stage_reg[i] <= mvenv_pkg::STG_IDLE;
                att_reg[i]   <= '0;
                sus_reg[i]   <= '0;
                dec_reg[i]   <= '0;
                peak_reg[i]  <= '0;
                level_reg[i] <= '0;
                pc_reg[i]    <= '0;
                sl_reg[i]    <= '0;
            end
        end else begin
            if (load_we) begin
                att_reg[cur_next]  <= in_att;
                sus_reg[cur_next]  <= in_sus;
                dec_reg[cur_next]  <= in_dec;
                peak_reg[cur_next] <= in_peak;
                rep_reg[cur_next]  <= in_rep;
            end
            if (act_we) begin
                active_reg[cur_reg] <= act_wd;
            end
            if (stg_we) begin
                stage_reg[cur_reg] <= stg_wd;
            end
            if (lvl_we) begin
                level_reg[cur_reg] <= lvl_wd;
            end
            if (pc_we) begin
                pc_reg[cur_reg] <= pc_wd;
            end
            if (sl_we) begin
                sl_reg[cur_reg] <= sl_wd;
            end
        end
    end

    // volume byte packing
    logic [7:0] vol_byte;

    always_comb begin
        if (!cfg.stereo_mode) begin
            vol_byte = {cur_level, cur_level};
        end else if (!cur_reg[0]) begin
            vol_byte = {cur_level, {LW{1'b0}}};
        end else begin
            vol_byte = {{LW{1'b0}}, cur_level};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_we) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_we) begin
            m_tdata_reg <= {5'b0, vol_byte, mvenv_pkg::CHAN_W'(cur_reg)};
            m_tlast_reg <= tick_reg ? last_reg : 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/mvenv_cfg.sv
// apb configuration registers: period scale and stereo mode
// depends on mvenv_pkg
module mvenv_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mvenv_pkg::PADDR_W-1:0]  paddr,
    input  logic [mvenv_pkg::PDATA_W-1:0]  pwdata,
    output logic [mvenv_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output mvenv_pkg::cfg_t                cfg
);

    logic [mvenv_pkg::RATE_W-1:0] scale_reg;
    logic                         stereo_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= mvenv_pkg::PERIOD_SCALE_RST;
            stereo_reg <= mvenv_pkg::STEREO_MODE_RST;
        end else if (wr_en) begin
            case (paddr[2])
                mvenv_pkg::REG_PERIOD_SCALE: scale_reg  <= pwdata[mvenv_pkg::RATE_W-1:0];
                mvenv_pkg::REG_STEREO_MODE:  stereo_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mvenv_pkg::REG_PERIOD_SCALE:
                prdata = {{(mvenv_pkg::PDATA_W-mvenv_pkg::RATE_W){1'b0}}, scale_reg};
            mvenv_pkg::REG_STEREO_MODE:
                prdata = {{(mvenv_pkg::PDATA_W-1){1'b0}}, stereo_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.period_scale = scale_reg;
    assign cfg.stereo_mode  = stereo_reg;

endmodule

FILE: dv/mvenv_envelope_checker.sv
// checker of the multichannel volume envelope unit: predicts the volume writes
// from input and apb transfers and compares them with the output transfers
// depends on mvenv_pkg
module mvenv_envelope_checker #(
    parameter logic NOTE_ON_CODE = 1'b1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [31:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mvenv_pkg::PADDR_W-1:0] paddr,
    input  logic [mvenv_pkg::PDATA_W-1:0] pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);

    localparam int NCH = mvenv_pkg::CHANNELS_DEF;

    typedef struct packed {
        logic [2:0] vreg;
        logic [7:0] vdata;
        logic       vlast;
    } vol_write_t;

    vol_write_t vol_writes_due[$];
    int         mismatches;

    logic [7:0]        scale_q;
    logic              stereo_q;
    logic              env_on    [NCH];
    mvenv_pkg::stage_t env_stage [NCH];
    logic [7:0]        atk_rate  [NCH];
    logic [7:0]        sus_rate  [NCH];
    logic [7:0]        dec_rate  [NCH];
    logic [3:0]        env_peak  [NCH];
    logic              env_rpt   [NCH];
    logic [3:0]        env_level [NCH];
    logic [15:0]       env_cnt   [NCH];
    logic [3:0]        sus_left  [NCH];

    function automatic logic [7:0] rate_for(int ch, mvenv_pkg::stage_t st);
        case (st)
            mvenv_pkg::STG_ATTACK:  return atk_rate[ch];
            mvenv_pkg::STG_SUSTAIN: return sus_rate[ch];
            mvenv_pkg::STG_DECAY:   return dec_rate[ch];
            default:                return 8'd0;
        endcase
    endfunction

    function automatic logic [15:0] period_of(int ch, mvenv_pkg::stage_t st);
        return {8'd0, scale_q} * {8'd0, rate_for(ch, st)};
    endfunction

    // first phase from 'from' on with a nonzero rate, else idle
    function automatic void enter_phase(int ch, mvenv_pkg::stage_t from);
        int   s;
        logic found;
        found          = 1'b0;
        env_stage[ch]  = mvenv_pkg::STG_IDLE;
        env_on[ch]     = 1'b0;
        for (s = int'(from); s <= int'(mvenv_pkg::STG_DECAY); s++) begin
            if (!found && rate_for(ch, mvenv_pkg::stage_t'(s)) != 8'd0) begin
                found         = 1'b1;
                env_stage[ch] = mvenv_pkg::stage_t'(s);
                env_on[ch]    = 1'b1;
                env_cnt[ch]   = period_of(ch, mvenv_pkg::stage_t'(s));
            end
        end
    endfunction

    function automatic void launch_envelope(int ch);
        if (sus_rate[ch] != 8'd0)
            sus_left[ch] = 4'(mvenv_pkg::SUSTAIN_STEPS_DEF);
        env_level[ch] = (atk_rate[ch] == 8'd0) ? env_peak[ch] : 4'd0;
        enter_phase(ch, mvenv_pkg::STG_ATTACK);
    endfunction

    function automatic void step_channel(int ch);
        mvenv_pkg::stage_t st;
        logic              expired;
        st = env_stage[ch];
        if (env_cnt[ch] <= 16'd1) begin
            expired     = 1'b1;
            env_cnt[ch] = period_of(ch, st);
        end else begin
            expired     = 1'b0;
            env_cnt[ch] = env_cnt[ch] - 16'd1;
        end
        if (expired) begin
            case (st)
                mvenv_pkg::STG_ATTACK: begin
                    if (env_level[ch] < env_peak[ch])
                        env_level[ch] = env_level[ch] + 4'd1;
                    if (env_level[ch] >= env_peak[ch])
                        enter_phase(ch, mvenv_pkg::STG_SUSTAIN);
                end
                mvenv_pkg::STG_SUSTAIN: begin
                    if (sus_left[ch] > 4'd0)
                        sus_left[ch] = sus_left[ch] - 4'd1;
                    if (sus_left[ch] == 4'd0) begin
                        // no decay phase: the level drops straight to zero
                        if (dec_rate[ch] == 8'd0)
                            env_level[ch] = 4'd0;
                        enter_phase(ch, mvenv_pkg::STG_DECAY);
                    end
                end
                mvenv_pkg::STG_DECAY: begin
                    if (env_level[ch] > 4'd0)
                        env_level[ch] = env_level[ch] - 4'd1;
                    if (env_level[ch] == 4'd0) begin
                        env_stage[ch] = mvenv_pkg::STG_IDLE;
                        env_on[ch]    = 1'b0;
                    end
                end
                default: begin
                    env_on[ch] = 1'b0;
                end
            endcase
        end
        if (!env_on[ch] && env_rpt[ch])
            launch_envelope(ch);
    endfunction

    function automatic logic [7:0] volume_byte(int ch);
        if (!stereo_q)
            return {env_level[ch], env_level[ch]};
        return (ch % 2 == 0) ? {env_level[ch], 4'd0} : {4'd0, env_level[ch]};
    endfunction

    function automatic void clear_model();
        int ch;
        scale_q  = mvenv_pkg::PERIOD_SCALE_RST;
        stereo_q = mvenv_pkg::STEREO_MODE_RST;
        for (ch = 0; ch < NCH; ch++) begin
            env_on[ch]    = 1'b0;
            env_stage[ch] = mvenv_pkg::STG_IDLE;
            atk_rate[ch]  = 8'd0;
            sus_rate[ch]  = 8'd0;
            dec_rate[ch]  = 8'd0;
            env_peak[ch]  = 4'd0;
            env_rpt[ch]   = 1'b0;
            env_level[ch] = 4'd0;
            env_cnt[ch]   = 16'd0;
            sus_left[ch]  = 4'd0;
        end
    endfunction

    function automatic void predict_item(logic f, logic [31:0] d);
        int         ch;
        int         n;
        vol_write_t w;
        n = 0;
        if (f == NOTE_ON_CODE) begin
            ch = int'(d[2:0]);
            // channels past the last one are dropped without a write
            if (ch < NCH) begin
                atk_rate[ch]  = d[10:3];
                sus_rate[ch]  = d[18:11];
                dec_rate[ch]  = d[26:19];
                env_peak[ch]  = d[30:27];
                env_rpt[ch]   = d[31];
                env_on[ch]    = 1'b0;
                env_stage[ch] = mvenv_pkg::STG_IDLE;
                launch_envelope(ch);
                w.vreg  = 3'(ch);
                w.vdata = volume_byte(ch);
                w.vlast = 1'b1;
                vol_writes_due.push_back(w);
            end
        end else begin
            for (ch = 0; ch < NCH; ch++) begin
                if (env_on[ch]) begin
                    step_channel(ch);
                    w.vreg  = 3'(ch);
                    w.vdata = volume_byte(ch);
                    w.vlast = 1'b0;
                    vol_writes_due.push_back(w);
                    n++;
                end
            end
            if (n > 0) begin
                w       = vol_writes_due[vol_writes_due.size()-1];
                w.vlast = 1'b1;
                vol_writes_due[vol_writes_due.size()-1] = w;
            end
        end
    endfunction

    function automatic void check_write();
        vol_write_t w;
        if (vol_writes_due.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected volume write: reg %0d data %02h last %0b",
                         m_tdata[2:0], m_tdata[10:3], m_tlast);
            mismatches++;
        end else begin
            w = vol_writes_due.pop_front();
            if (m_tdata[2:0] !== w.vreg || m_tdata[10:3] !== w.vdata ||
                m_tlast !== w.vlast || m_tdata[15:11] !== 5'd0) begin
                if (mismatches < 10)
                    $display("volume write mismatch: expected reg %0d data %02h last %0b,",
                             w.vreg, w.vdata, w.vlast,
                             " got reg %0d data %02h last %0b pad %02h",
                             m_tdata[2:0], m_tdata[10:3], m_tlast, m_tdata[15:11]);
                mismatches++;
            end
        end
    endfunction

    initial begin
        mismatches = 0;
        clear_model();
    end

    // outputs first: a write taken at the same edge as an input belongs to older items
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
            vol_writes_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_write();
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mvenv_pkg::REG_PERIOD_SCALE)
                    scale_q = pwdata[7:0];
                else
                    stereo_q = pwdata[0];
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser[0], s_tdata);
        end
        pending    <= vol_writes_due.size();
        fail_count <= mismatches;
    end

endmodule

FILE: dv/tb_multichannel_volume_envelope_unit.sv
// testbench top of the multichannel volume envelope unit: clock, reset, apb
// writes, input items and output back-pressure, final verdict
// depends on mvenv_pkg, multichannel_volume_envelope_unit and mvenv_envelope_checker
module tb_multichannel_volume_envelope_unit;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_NOTE_ON = 1'b1;

    localparam logic [mvenv_pkg::PADDR_W-1:0] ADDR_PERIOD_SCALE =
        {mvenv_pkg::REG_PERIOD_SCALE, 2'b00};
    localparam logic [mvenv_pkg::PADDR_W-1:0] ADDR_STEREO_MODE  =
        {mvenv_pkg::REG_STEREO_MODE, 2'b00};

    localparam int RESET_CYCLES      = 8;
    localparam int DRAIN_CYCLES      = 60;
    localparam int LONG_HOLD         = 250;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int NUM_SETTINGS      = 6;
    localparam int ITEMS_PER_SETTING = 64;

    logic                            aclk;
    logic                            aresetn;
    logic [31:0]                     s_tdata;
    logic [0:0]                      s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [15:0]                     m_tdata;
    logic                            m_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mvenv_pkg::PADDR_W-1:0]   paddr;
    logic [mvenv_pkg::PDATA_W-1:0]   pwdata;
    logic [mvenv_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;
    int                              fail_count;
    int                              pending;
    bit                              no_idle;
    bit                              hold_req;

    multichannel_volume_envelope_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mvenv_envelope_checker #(
        .NOTE_ON_CODE (FUNC_NOTE_ON)
    ) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small rates dominate so envelopes run through all phases
    function automatic logic [7:0] rand_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 8'd0;
        if (r < 80)
            return 8'($urandom_range(1, 3));
        if (r < 95)
            return 8'($urandom_range(4, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // {stereo_mode, period_scale} of each phase
    function automatic logic [8:0] setting_of(int k);
        case (k)
            0:       return {1'b1, 8'd1};
            1:       return {1'b0, 8'd2};
            2:       return {1'b1, 8'd0};
            3:       return {1'b0, 8'd1};
            4:       return {1'b1, 8'd255};
            default: return {1'b0, 8'd3};
        endcase
    endfunction

    task automatic reg_write(logic [mvenv_pkg::PADDR_W-1:0] addr, logic [31:0] value,
                             logic [31:0] field_mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= (value & field_mask) | ($urandom() & ~field_mask);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_item(logic f, logic [31:0] d);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic note_on(logic [2:0] ch, logic [7:0] atk, logic [7:0] sus,
                           logic [7:0] dec, logic [3:0] pk, logic rpt);
        push_item(FUNC_NOTE_ON, {rpt, pk, dec, sus, atk, ch});
    endtask

    // the fields of a tick are ignored, fill them with noise
    task automatic tick();
        push_item(FUNC_TICK, $urandom());
    endtask

    task automatic run_random(int n);
        int         done;
        logic [2:0] ch;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 99) < 62) begin
                tick();
                done++;
            end else begin
                if ($urandom_range(0, 99) < 92)
                    ch = 3'($urandom_range(0, mvenv_pkg::CHANNELS_DEF - 1));
                else
                    ch = 3'($urandom_range(mvenv_pkg::CHANNELS_DEF, 7));
                note_on(ch, rand_rate(), rand_rate(), rand_rate(),
                        4'($urandom_range(0, 15)), $urandom_range(0, 99) < 30);
                if (ch < mvenv_pkg::CHANNELS_DEF)
                    done++;
            end
        end
    endtask

    // wait for every predicted write, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : sink
        int n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            n = gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int         k;
        logic [8:0] cfg;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= FUNC_TICK;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        reg_write(ADDR_PERIOD_SCALE, 32'd1, 32'hFF);
        reg_write(ADDR_STEREO_MODE, 32'd0, 32'h1);

        tick();                                             // nothing active
        note_on(3'd6, 8'hFF, 8'hFF, 8'hFF, 4'hF, 1'b1);     // no such channel
        note_on(3'd7, 8'd1, 8'd1, 8'd1, 4'd5, 1'b0);
        note_on(3'd0, 8'd0, 8'd0, 8'd0, 4'hF, 1'b0);        // all rates zero
        note_on(3'd1, 8'd1, 8'd0, 8'd0, 4'd0, 1'b0);        // level already at peak
        note_on(3'd2, 8'd0, 8'd0, 8'd1, 4'd0, 1'b0);        // decay starts at zero
        note_on(3'd3, 8'd0, 8'd1, 8'd0, 4'd9, 1'b0);        // sustain without decay
        note_on(3'd4, 8'd2, 8'd0, 8'd0, 4'd3, 1'b0);        // attack only, keeps peak
        note_on(3'd5, 8'd1, 8'd0, 8'd1, 4'd2, 1'b1);        // repeating
        push_item(FUNC_TICK, 32'hFFFF_FFFF);
        repeat (8) tick();
        note_on(3'd4, 8'hFF, 8'hFF, 8'hFF, 4'hF, 1'b1);
        note_on(3'd0, 8'd1, 8'd1, 8'd1, 4'hF, 1'b1);
        repeat (5) tick();
        settle();

        for (k = 0; k < NUM_SETTINGS; k++) begin
            cfg = setting_of(k);
            reg_write(ADDR_PERIOD_SCALE, {24'd0, cfg[7:0]}, 32'hFF);
            reg_write(ADDR_STEREO_MODE, {31'd0, cfg[8]}, 32'h1);
            no_idle  = (k == 3);
            hold_req = (k == 1);
            run_random(ITEMS_PER_SETTING);
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
